// ===== hw/rtl/att_pkg.sv =====
// Shared types, token kind codes and mnemonic table for the assembly text tokenizer.
package att_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        hex_error;
    logic        last_of_item;
  } tok_item_t;

  localparam logic [4:0] KIND_LABEL   = 5'd0;
  localparam logic [4:0] KIND_DEC     = 5'd1;
  localparam logic [4:0] KIND_HEX     = 5'd2;
  localparam logic [4:0] KIND_MNEM0   = 5'd3;
  localparam logic [4:0] KIND_COMMA   = 5'd18;
  localparam logic [4:0] KIND_UNKNOWN = 5'd19;
  localparam logic [4:0] KIND_END     = 5'd20;

  localparam int KW_TABLE = 15;

  // right-justified text, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_TABLE] = '{
    64'("jns"), 64'("load"), 64'("store"), 64'("add"), 64'("subt"),
    64'("input"), 64'("output"), 64'("halt"), 64'("skipcond"), 64'("jump"),
    64'("clear"), 64'("addi"), 64'("jumpi"), 64'("loadi"), 64'("storei")
  };

  localparam logic [3:0] KW_LEN [KW_TABLE] = '{
    4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4,
    4'd8, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5, 4'd6
  };

  // character k of mnemonic i, meaningful only for k below its length
  function automatic logic [7:0] kw_char(input int i, input logic [2:0] k);
    logic [3:0]  sh;
    logic [63:0] w;
    sh = KW_LEN[i] - 4'd1 - {1'b0, k};
    w  = KW_TEXT[i] >> {sh, 3'b000};
    return w[7:0];
  endfunction

endpackage

// ===== hw/rtl/assembly_text_tokenizer.sv =====
// Streaming assembly tokenizer: character scanner, keyword matchers and token queue.
//
// Usage:
//   Characters enter on the char channel (char_valid / char_stall / char_item),
//   one per item. Tokens leave on the tok channel (tok_valid / tok_stall /
//   tok_item), one per item, with last_of_item set on the final token that an
//   input character caused. A character yields zero, one or two tokens.
//   A token is written into the token queue when the character that emits it
//   is taken. The scanner and all fifteen keyword comparators are combinational,
//   so one character is accepted per cycle while char_stall is low; the rate is
//   set by the four-entry token queue, which drains one token per cycle while
//   tok_stall is low. A character that yields two tokens takes two output slots.
//   char_stall rises while the queue holds three or more tokens, so a
//   character that yields two tokens always has room.
//   When the receiver stalls, the head token holds steady on tok_item and
//   the queue fills until char_stall rises.
//   Reset (rst, synchronous) empties the queue and returns the scanner to
//   idle at offset zero. An end-of-text token does the same for the scanner.
module assembly_text_tokenizer #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_COUNT = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  att_pkg::char_item_t char_item,
  output logic               tok_valid,
  input  logic               tok_stall,
  output att_pkg::tok_item_t  tok_item
);
  import att_pkg::*;

  localparam int PW     = POSITION_BITS;
  localparam int KW     = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;
  localparam logic [PW-1:0] POS_MAX = '1;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_COMMENT   = 3'd1;
  localparam logic [2:0] MODE_WORD      = 3'd2;
  localparam logic [2:0] MODE_NUMBER    = 3'd3;
  localparam logic [2:0] MODE_ZERO      = 3'd4;
  localparam logic [2:0] MODE_HEXPREFIX = 3'd5;

  logic [2:0]    mode, mode_next;
  logic [PW-1:0] position;
  logic [PW-1:0] token_start, token_start_next;
  logic [15:0]   run_length, run_length_next;
  logic [KW-1:0] alive, alive_next;
  logic          hex_pending, hex_pending_next;

  tok_item_t       queue [QDEPTH];
  logic [QAW-1:0]  head, tail;
  logic [QCW-1:0]  count;

  logic [7:0] c;
  logic       eot, isend, relex, finished;
  logic       p1_emit, p2_emit;
  tok_item_t  p1_tok, p2_tok, tok_a, tok_b;
  logic [1:0] n_tok, n_push;
  logic       accept, pop;

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
    return (v == POS_MAX) ? v : v + PW'(1);
  endfunction

  function automatic logic [15:0] sat_off(input logic [PW-1:0] v);
    logic [PW+15:0] w;
    w = {16'd0, v};
    return (w > (PW+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return (x >= "0") && (x <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] x);
    return ((x >= "a") && (x <= "z")) || ((x >= "A") && (x <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] x);
    return (x == 8'h0A) || (x == 8'h0D) || (x == 8'h09) || (x == " ");
  endfunction

  function automatic logic [KW-1:0] track(input logic [KW-1:0] a, input logic [15:0] k,
                                          input logic [7:0] x);
    logic [KW-1:0] r;
    logic [7:0]    lc;
    lc = ((x >= "A") && (x <= "Z")) ? x + 8'd32 : x;
    for (int i = 0; i < KW; i++) begin
      r[i] = a[i] && (k < {12'd0, KW_LEN[i]}) && (lc == kw_char(i, k[2:0]));
    end
    return r;
  endfunction

  function automatic logic [4:0] word_kind(input logic [KW-1:0] a, input logic [15:0] len);
    logic [4:0] kind;
    kind = KIND_LABEL;
    for (int i = KW - 1; i >= 0; i--) begin
      if (a[i] && (len == {12'd0, KW_LEN[i]})) begin
        kind = KIND_MNEM0 + 5'(i);
      end
    end
    return kind;
  endfunction

  function automatic tok_item_t make_tok(input logic [4:0] kind, input logic [PW-1:0] start,
                                         input logic [15:0] len, input logic err);
    tok_item_t t;
    t.token_kind   = kind;
    t.start_offset = sat_off(start);
    t.token_length = len;
    t.hex_error    = err;
    t.last_of_item = 1'b0;
    return t;
  endfunction

  always_comb begin
    c                = char_item.ch;
    eot              = char_item.end_of_text;
    isend            = eot || (c == 8'd0);
    mode_next        = mode;
    token_start_next = token_start;
    run_length_next  = run_length;
    alive_next       = alive;
    hex_pending_next = hex_pending;
    relex            = 1'b0;
    finished         = 1'b0;
    p1_emit          = 1'b0;
    p2_emit          = 1'b0;
    p1_tok           = '0;
    p2_tok           = '0;

    unique case (mode)
      MODE_COMMENT: begin
        if (isend) begin
          relex = 1'b1;
        end else if (c == 8'h0A) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (!isend && (is_letter(c) || is_digit(c))) begin
          alive_next = track(alive, run_length, c);
          if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
        end else begin
          p1_emit   = 1'b1;
          p1_tok    = make_tok(word_kind(alive, run_length), token_start, run_length, 1'b0);
          mode_next = MODE_IDLE;
          relex     = 1'b1;
        end
      end
      MODE_ZERO, MODE_NUMBER: begin
        if (mode == MODE_ZERO && !isend && (c == "x" || c == "X")) begin
          mode_next = MODE_HEXPREFIX;
        end else if (!isend && is_digit(c)) begin
          mode_next = MODE_NUMBER;
          if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
        end else begin
          p1_emit   = 1'b1;
          p1_tok    = make_tok(hex_pending ? KIND_HEX : KIND_DEC, token_start, run_length,
                               1'b0);
          mode_next = MODE_IDLE;
          relex     = 1'b1;
        end
      end
      MODE_HEXPREFIX: begin
        if (!isend && is_digit(c)) begin
          mode_next        = MODE_NUMBER;
          hex_pending_next = 1'b1;
          token_start_next = position;
          run_length_next  = 16'd1;
        end else if (eot) begin
          p1_emit = 1'b1;
          p1_tok  = make_tok(KIND_HEX, (position != '0) ? position - PW'(1) : '0, 16'd1, 1'b1);
          relex   = 1'b1;
        end else begin
          p1_emit   = 1'b1;
          p1_tok    = make_tok(KIND_HEX, position, 16'd1, 1'b1);
          mode_next = MODE_IDLE;
          relex     = (c == 8'd0);
        end
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    if (relex) begin
      priority if (isend) begin
        p2_emit  = 1'b1;
        p2_tok   = make_tok(KIND_END, eot ? position : pos_inc(position), 16'd0, 1'b0);
        finished = 1'b1;
      end else if (is_space(c)) begin
        mode_next = MODE_IDLE;
      end else if (c == ";") begin
        mode_next = MODE_COMMENT;
      end else if (is_letter(c)) begin
        mode_next        = MODE_WORD;
        token_start_next = position;
        alive_next       = track('1, 16'd0, c);
        run_length_next  = 16'd1;
      end else if (is_digit(c)) begin
        mode_next        = (c == "0") ? MODE_ZERO : MODE_NUMBER;
        hex_pending_next = 1'b0;
        token_start_next = position;
        run_length_next  = 16'd1;
      end else if (c == "," || c == ":") begin
        p2_emit   = 1'b1;
        p2_tok    = make_tok(KIND_COMMA, position, 16'd1, 1'b0);
        mode_next = MODE_IDLE;
      end else begin
        p2_emit   = 1'b1;
        p2_tok    = make_tok(KIND_UNKNOWN, position, 16'd1, 1'b0);
        mode_next = MODE_IDLE;
      end
    end

    n_tok              = {1'b0, p1_emit} + {1'b0, p2_emit};
    tok_a              = p1_emit ? p1_tok : p2_tok;
    tok_a.last_of_item = !(p1_emit && p2_emit);
    tok_b              = p2_tok;
    tok_b.last_of_item = 1'b1;
  end

  assign char_stall = (count >= QCW'(QDEPTH - 1));
  assign tok_valid  = (count != '0);
  assign tok_item   = queue[head];
  assign accept     = char_valid && !char_stall;
  assign pop        = tok_valid && !tok_stall;
  assign n_push     = accept ? n_tok : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position    <= '0;
      token_start <= '0;
      run_length  <= '0;
      alive       <= '1;
      hex_pending <= 1'b0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
    end else begin
      if (accept) begin
        if (finished) begin
          mode        <= MODE_IDLE;
          position    <= '0;
          token_start <= '0;
          run_length  <= '0;
          alive       <= '1;
          hex_pending <= 1'b0;
        end else begin
          mode        <= mode_next;
          position    <= pos_inc(position);
          token_start <= token_start_next;
          run_length  <= run_length_next;
          alive       <= alive_next;
          hex_pending <= hex_pending_next;
        end
      end
      head  <= head + QAW'(pop);
      tail  <= tail + QAW'(n_push);
      count <= count + QCW'(n_push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[tail] <= tok_a;
    end
    if (n_push == 2'd2) begin
      queue[tail + QAW'(1)] <= tok_b;
    end
  end

endmodule

// ===== hw/rtl/att_checker.sv =====
// Port-level checks for the assembly text tokenizer, bound to the top level.
module att_checker (
  input logic               clk,
  input logic               rst,
  input logic               char_stall,
  input logic               tok_valid,
  input logic               tok_stall,
  input att_pkg::tok_item_t  tok_item
);
  import att_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
    else $error("token changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !tok_valid && !char_stall)
    else $error("queue not empty after reset");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind == KIND_END |->
      tok_item.last_of_item && tok_item.token_length == 16'd0 && !tok_item.hex_error)
    else $error("bad end of text token");

  a_single_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_item.token_kind == KIND_COMMA || tok_item.token_kind == KIND_UNKNOWN)
      |-> tok_item.token_length == 16'd1 && tok_item.last_of_item)
    else $error("comma or unknown token malformed");

  a_hex_err: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.hex_error |->
      tok_item.token_kind == KIND_HEX && tok_item.token_length == 16'd1)
    else $error("errored hex token malformed");

endmodule

bind assembly_text_tokenizer att_checker u_att_checker (.*);
